// ----- sv/mbt_pkg.sv -----
// mbt_pkg: shared types and codes for the multiset bag table
// opcode and status codes, controller state type; no dependencies
`default_nettype none

package mbt_pkg;

  // opcodes carried by an input beat
  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_ERASE_ONE = 3'd1;
  localparam logic [2:0] OP_ERASE_ALL = 3'd2;
  localparam logic [2:0] OP_COUNT     = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- sv/multiset_bag_table.sv -----
// Multiset bag table: values live in a single-port-read table memory with an
// occupancy count; one item is processed at a time and gives one result beat.
// Insert, an unknown opcode, an out-of-range read and a search of an empty
// table offer their result in the cycle after the input beat; a valid read
// first passes through S_RDATA for the registered read data. Count,
// erase-first and erase-all walk the table one cycle at a time. Each cycle
// either steps to the next entry or removes one. A removal moves the last
// entry into the freed slot and tests it there. The input stays stalled
// until the cycle after the result beat. The read port of the table sets
// this pace.
// depends on mbt_pkg and mbt_mem
`default_nettype none

module multiset_bag_table
  import mbt_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] item_value,
  input  wire logic [5:0]  slot_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] read_value,
  output logic      [6:0]  match_count,
  output logic      [1:0]  status,
  output logic      [6:0]  occupancy
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > 6) ? CW : 6;

  state_t                state, state_next;
  logic [2:0]            op, op_next;
  logic [VALUE_BITS-1:0] val, val_next;
  logic [AW-1:0]         idx, idx_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [CW-1:0]         fill, fill_next;
  logic [31:0]           rdv, rdv_next;
  logic [1:0]            stat, stat_next;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;

  logic                  accept;
  logic [VALUE_BITS-1:0] val_in;
  logic                  hit;
  logic                  more;
  logic [CW-1:0]         fill_dec;
  logic                  at_last;
  logic                  slot_ok;

  mbt_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // handshake and shared conditions
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign accept    = in_valid && !in_stall;
  assign val_in    = VALUE_BITS'(item_value);
  assign hit       = (mem_rdata == val);
  assign more      = (CW'(idx) + CW'(1)) < fill;
  assign fill_dec  = fill - CW'(1);
  assign at_last   = (CW'(idx) == fill_dec);
  assign slot_ok   = IW'(slot_index) < IW'(fill);

  // result fields
  assign read_value  = rdv;
  assign match_count = 7'(cnt);
  assign status      = stat;
  assign occupancy   = 7'(fill);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode) inside
            OP_INSERT: state_next = S_DONE;
            OP_READ:   state_next = slot_ok ? S_RDATA : S_DONE;
            OP_ERASE_ONE, OP_ERASE_ALL, OP_COUNT:
              state_next = (fill == '0) ? S_DONE : S_SCAN;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_RDATA: state_next = S_DONE;
      S_SCAN: begin
        if (hit && op != OP_COUNT) begin
          state_next = at_last ? S_DONE : S_MOVE;
        end else begin
          state_next = more ? S_SCAN : S_DONE;
        end
      end
      S_MOVE: begin
        if (op == OP_ERASE_ONE) begin
          state_next = S_DONE;
        end else if (hit) begin
          state_next = at_last ? S_DONE : S_MOVE;
        end else begin
          state_next = more ? S_SCAN : S_DONE;
        end
      end
      S_DONE: state_next = out_stall ? S_DONE : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and table accesses
  always_comb begin
    op_next   = op;
    val_next  = val;
    idx_next  = idx;
    cnt_next  = cnt;
    fill_next = fill;
    rdv_next  = rdv;
    stat_next = stat;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_next   = opcode;
          val_next  = val_in;
          idx_next  = '0;
          cnt_next  = '0;
          rdv_next  = '0;
          stat_next = ST_OK;
          unique case (opcode) inside
            OP_INSERT: begin
              if (fill < CW'(CAPACITY)) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(fill);
                mem_wdata = val_in;
                fill_next = fill + CW'(1);
              end else begin
                stat_next = ST_FULL;
              end
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = AW'(slot_index);
              if (!slot_ok) begin
                stat_next = ST_RANGE;
              end
            end
            OP_ERASE_ONE, OP_ERASE_ALL, OP_COUNT: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
            default: ;
          endcase
        end
      end
      S_RDATA: rdv_next = 32'(mem_rdata);
      S_SCAN: begin
        // erase hit: drop the count and fetch the last entry
        if (hit && op != OP_COUNT) begin
          fill_next = fill_dec;
          cnt_next  = cnt + CW'(1);
          if (!at_last) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(fill_dec);
          end
        end else begin
          if (hit) begin
            cnt_next = cnt + CW'(1);
          end
          if (more) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(CW'(idx) + CW'(1));
            idx_next  = AW'(CW'(idx) + CW'(1));
          end
        end
      end
      S_MOVE: begin
        // last entry fills the freed slot, then is tested in place unless erasing one
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        if (op != OP_ERASE_ONE) begin
          if (hit) begin
            fill_next = fill_dec;
            cnt_next  = cnt + CW'(1);
            if (!at_last) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(fill_dec);
            end
          end else if (more) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(CW'(idx) + CW'(1));
            idx_next  = AW'(CW'(idx) + CW'(1));
          end
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op   <= op_next;
    val  <= val_next;
    idx  <= idx_next;
    cnt  <= cnt_next;
    rdv  <= rdv_next;
    stat <= stat_next;
  end

`ifndef SYNTHESIS
  // a slot is never read and written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("table read and write hit the same slot");

  // the scan index always points inside the occupied part
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CW'(idx) < fill))
    else $error("scan index beyond occupancy");

  // occupancy only grows on an accepted beat
  a_no_growth_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (fill <= $past(fill)))
    else $error("occupancy grew while busy");

  // a full status comes only with a full table
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stat == ST_FULL) |-> (fill == CW'(CAPACITY)))
    else $error("full status with free slots");

  // occupancy never exceeds capacity
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    accept |=> (fill <= CW'(CAPACITY)))
    else $error("occupancy beyond capacity");
`endif

endmodule

`default_nettype wire

// ----- sv/mbt_mem.sv -----
// mbt_mem: entry table of the multiset bag
// one write port, one read port, registered read data; no dependencies
`default_nettype none

module mbt_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
